FILE: rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sgst_pkg.sv
// ---------------------------------------------------------------------------
// sgst_pkg
// shared types and constants of the segmented grid slot translator
// ---------------------------------------------------------------------------
package sgst_pkg;

   localparam int MaxRegions = 16;
   localparam int IdxW       = $clog2(MaxRegions);
   localparam int CntW       = $clog2(MaxRegions + 1);
   localparam int SlotW      = 21;
   localparam int SumW       = 25;
   localparam int RecW       = 48;

   typedef enum logic [1:0] {
      OP_UPSERT = 2'd0,
      OP_TO_SLOT = 2'd1,
      OP_TO_POS = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   function automatic logic [SlotW-1:0] cells_of(input logic [7:0] w, input logic [7:0] h,
                                                 input logic [15:0] c);
      logic [15:0] t;
      begin
         t = 16'(w) * 16'(h);
         if (w == 8'd0 || h == 8'd0) cells_of = '0;
         else if (c != 16'd0 && c < t) cells_of = SlotW'(c);
         else cells_of = SlotW'(t);
      end
   endfunction

endpackage

FILE: rtl/segmented_grid_slot_translator_core.sv
// ---------------------------------------------------------------------------
// segmented_grid_slot_translator_core
// region table in ram, grid position to flat slot and back
// ---------------------------------------------------------------------------
// the table scan walks the region ram one entry a cycle, up to 16 entries;
// reverse mapping uses a bit-serial divider
// one item at a time, the next taken the cycle after its result transfer
// reset clears the region count and control; the ram needs no clearing
module segmented_grid_slot_translator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op, region_tag, pos_x, pos_y, slot_in, region_width, region_height, region_cap
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, slot_out, col_out, row_out
   output logic [55:0] rsp_tdata
);
   import sgst_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;
   logic [88:0] item_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] i_ff, i_in;
   logic [SumW-1:0] off_ff, off_in;
   logic found_ff, found_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic [RecW-1:0] hitrec_ff, hitrec_in;
   logic [SumW-1:0] hitoff_ff, hitoff_in;
   logic rd_ok_ff;
   logic [1:0] st_ff, st_in;
   logic [SlotW-1:0] so_ff, so_in, row_ff, row_in;
   logic [7:0] col_ff, col_in;
   logic out_v_ff, out_v_in;

   logic ram_we;
   logic [IdxW-1:0] ram_addr;
   logic [RecW-1:0] ram_wdata, ram_rdata;

   op_type op;
   logic [15:0] tag, cap;
   logic signed [8:0] px, py;
   logic [SlotW-1:0] slot;
   logic [7:0] wd, ht;
   logic div_start, div_done;
   logic [SlotW-1:0] div_q, div_dd;
   logic [7:0] div_r;
   logic [SumW-1:0] loc, sum, cc;
   logic [16:0] prod;

   assign op   = op_type'(item_ff[1:0]);
   assign tag  = item_ff[17:2];
   assign px   = item_ff[26:18];
   assign py   = item_ff[35:27];
   assign slot = item_ff[56:36];
   assign wd   = item_ff[64:57];
   assign ht   = item_ff[72:65];
   assign cap  = item_ff[88:73];

   sgst_ram #(.Width(RecW), .Depth(MaxRegions)) u_table (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   sgst_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dd),
      .divisor(hitrec_ff[23:16]), .done(div_done), .quot(div_q), .rem(div_r)
   );

   assign req_tready = state_ff == S_IDLE && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, row_ff, col_ff, so_ff, st_ff};

   assign prod   = 17'(py[7:0]) * 17'(hitrec_ff[23:16]);
   assign loc    = SumW'(prod) + SumW'(px[7:0]);
   assign sum    = hitoff_ff + loc;
   assign cc     = SumW'(cells_of(hitrec_ff[23:16], hitrec_ff[31:24], hitrec_ff[47:32]));
   assign div_dd = SlotW'(SumW'(slot) - hitoff_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid && req_tready) state_in = S_SCAN;
         S_SCAN:  if (found_ff || (i_ff == count_ff && !rd_ok_ff)) state_in = S_CHECK;
         S_CHECK: state_in = div_start ? S_DIV : S_DONE;
         S_DIV:   if (div_done) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      i_in = i_ff;
      off_in = off_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      hitrec_in = hitrec_ff;
      hitoff_in = hitoff_ff;
      st_in = st_ff;
      so_in = so_ff;
      col_in = col_ff;
      row_in = row_ff;
      out_v_in = out_v_ff && !rsp_tready;
      ram_we = 1'b0;
      ram_addr = i_ff[IdxW-1:0];
      ram_wdata = {cap, ht, wd, tag};
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            i_in = '0;
            off_in = '0;
            found_in = 1'b0;
         end
         S_SCAN: begin
            if (rd_ok_ff && !found_ff) begin
               if (ram_rdata[15:0] == tag) begin
                  found_in = 1'b1;
                  hit_in = IdxW'(i_ff - 1'b1);
                  hitrec_in = ram_rdata;
                  hitoff_in = off_ff;
               end else begin
                  off_in = off_ff + SumW'(cells_of(ram_rdata[23:16], ram_rdata[31:24],
                                                   ram_rdata[47:32]));
               end
            end
            if (!found_in && i_ff != count_ff) i_in = i_ff + 1'b1;
         end
         S_CHECK: begin
            st_in = ST_MISS;
            so_in = '0;
            col_in = '0;
            row_in = '0;
            case (op)
               OP_UPSERT: begin
                  if (found_ff) begin
                     ram_we = 1'b1;
                     ram_addr = hit_ff;
                     st_in = ST_OK;
                  end else if (count_ff != CntW'(MaxRegions)) begin
                     ram_we = 1'b1;
                     ram_addr = count_ff[IdxW-1:0];
                     count_in = count_ff + 1'b1;
                     st_in = ST_OK;
                  end else st_in = ST_FULL;
               end
               OP_TO_SLOT: begin
                  if (!px[8] && !py[8] && found_ff && hitrec_ff[23:16] != 8'd0 &&
                      hitrec_ff[31:24] != 8'd0 &&
                      !(hitrec_ff[47:32] != 16'd0 && loc >= SumW'(hitrec_ff[47:32])) &&
                      sum <= SumW'({SlotW{1'b1}})) begin
                     st_in = ST_OK;
                     so_in = SlotW'(sum);
                  end
               end
               OP_TO_POS: begin
                  if (found_ff && SumW'(slot) >= hitoff_ff && hitrec_ff[23:16] != 8'd0 &&
                      !(cc != '0 && SumW'(div_dd) >= cc))
                     div_start = 1'b1;
               end
               default: st_in = ST_MISS;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               st_in = ST_OK;
               col_in = div_r;
               row_in = div_q;
            end
         end
         S_DONE: out_v_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
         rd_ok_ff <= state_ff == S_SCAN && i_ff != count_ff && !found_in;
      end
      if (req_tvalid && req_tready) item_ff <= req_tdata[88:0];
      i_ff <= i_in;
      off_ff <= off_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      hitrec_ff <= hitrec_in;
      hitoff_ff <= hitoff_in;
      st_ff <= st_in;
      so_ff <= so_in;
      col_ff <= col_in;
      row_ff <= row_in;
   end

   `ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= CntW'(MaxRegions), "region count overflow")
   `ASSERT_NEXT(a_out_hold, clock, reset, out_v_ff && !rsp_tready, out_v_ff, "result dropped")
   `ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(req_tready && state_ff != S_IDLE),
                  "ready while busy")
   `ASSERT_ALWAYS(a_ok_fields, clock, reset, !out_v_ff || st_ff == ST_OK ||
                  (so_ff == '0 && col_ff == '0 && row_ff == '0), "payload on failure")
endmodule

FILE: rtl/sgst_ram.sv
// ---------------------------------------------------------------------------
// sgst_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module sgst_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

FILE: rtl/sgst_div.sv
// ---------------------------------------------------------------------------
// sgst_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module sgst_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sgst_pkg::SlotW-1:0] dividend,
   input  logic [7:0]                 divisor,
   output logic                       done,
   output logic [sgst_pkg::SlotW-1:0] quot,
   output logic [7:0]                 rem
);
   import sgst_pkg::*;
   `include "assert_macros.svh"

   localparam int StepW = $clog2(SlotW + 1);

   logic [SlotW-1:0] q_ff, q_in;
   logic [8:0]       r_ff, r_in;
   logic [7:0]       d_ff, d_in;
   logic [StepW-1:0] n_ff, n_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [8:0]       trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[7:0], q_ff[SlotW-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         n_in = StepW'(SlotW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[SlotW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[SlotW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff[7:0];

   `ASSERT_NEXT(a_div_busy, clock, reset, start, busy_ff, "divider did not start")
   `ASSERT_ALWAYS(a_div_cnt, clock, reset, !busy_ff || n_ff != '0, "divider count ran out")
endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// checks the segmented grid slot translator against a behavioural model of the
// region table, with random gaps on both stream sides
// ---------------------------------------------------------------------------
module testbench;
   import sgst_pkg::*;

   typedef struct {
      op_type      op;
      logic [15:0] tag;
      logic [8:0]  px;
      logic [8:0]  py;
      logic [20:0] slot;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [15:0] cap;
   } cmd_type;

   typedef struct {
      status_type  st;
      logic [20:0] slot;
      logic [7:0]  col;
      logic [20:0] row;
   } answer_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;

   segmented_grid_slot_translator_core u_dut (.*);

   cmd_type     pending_cmds[$];
   answer_type  expected_answers[$];
   logic [15:0] mdl_tag[MaxRegions];
   logic [7:0]  mdl_w[MaxRegions];
   logic [7:0]  mdl_h[MaxRegions];
   logic [15:0] mdl_cap[MaxRegions];
   int          mdl_count;
   int          errors = 0;
   int          idle_cycles = 0;
   bit          hold_sender = 0;
   bit          stim_done = 0;
   bit          in_xfer = 0;
   int          send_gap = 0;
   int          take_gap = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic int region_cells(int i);
      int t;
      if (mdl_w[i] == 0 || mdl_h[i] == 0) return 0;
      t = mdl_w[i] * mdl_h[i];
      if (mdl_cap[i] != 0 && mdl_cap[i] < t) return mdl_cap[i];
      return t;
   endfunction

   function automatic int region_base(int idx);
      int s;
      s = 0;
      for (int i = 0; i < idx; i++) s += region_cells(i);
      return s;
   endfunction

   function automatic int lookup_tag(logic [15:0] tag);
      for (int i = 0; i < mdl_count; i++)
         if (mdl_tag[i] == tag) return i;
      return mdl_count;
   endfunction

   function automatic answer_type translate(cmd_type c);
      answer_type a;
      int idx, x, y, loc, s, off, cc;
      bit hit;
      a = '{ST_MISS, '0, '0, '0};
      idx = lookup_tag(c.tag);
      hit = idx < mdl_count;
      x = $signed(c.px);
      y = $signed(c.py);
      case (c.op)
         OP_UPSERT: begin
            if (!hit && mdl_count < MaxRegions) begin
               idx = mdl_count;
               mdl_count++;
               hit = 1;
            end
            if (hit) begin
               mdl_tag[idx] = c.tag;
               mdl_w[idx] = c.w;
               mdl_h[idx] = c.h;
               mdl_cap[idx] = c.cap;
               a.st = ST_OK;
            end else a.st = ST_FULL;
         end
         OP_TO_SLOT: begin
            if (x >= 0 && y >= 0 && hit && mdl_w[idx] != 0 && mdl_h[idx] != 0) begin
               loc = y * mdl_w[idx] + x;
               if (!(mdl_cap[idx] != 0 && loc >= mdl_cap[idx])) begin
                  s = region_base(idx) + loc;
                  if (s <= 21'h1FFFFF) begin
                     a.st = ST_OK;
                     a.slot = 21'(s);
                  end
               end
            end
         end
         OP_TO_POS: begin
            if (hit) begin
               off = region_base(idx);
               if (c.slot >= off && mdl_w[idx] != 0) begin
                  loc = c.slot - off;
                  cc = region_cells(idx);
                  if (!(cc > 0 && loc >= cc)) begin
                     a.st = ST_OK;
                     a.col = 8'(loc % mdl_w[idx]);
                     a.row = 21'(loc / mdl_w[idx]);
                  end
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic cmd_type make_cmd(op_type op, logic [15:0] tag);
      cmd_type c;
      c.op = op;
      c.tag = tag;
      c.px = 9'($urandom);
      c.py = 9'($urandom);
      c.slot = 21'($urandom);
      c.w = 8'($urandom);
      c.h = 8'($urandom);
      c.cap = 16'($urandom);
      return c;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      cmd_type c;
      bit hold;
      if (!reset) begin
         hold = req_tvalid && !in_xfer;
         if (in_xfer) begin
            in_xfer = 0;
            send_gap = gap_len();
         end
         if (hold) begin
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 0;
         end else if (pending_cmds.size() > 0 && !hold_sender) begin
            c = pending_cmds[0];
            req_tdata <= {7'd0, c.cap, c.h, c.w, c.slot, c.py, c.px, c.tag, c.op};
            req_tvalid <= 1;
         end else req_tvalid <= 0;
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if ($urandom_range(0, 9) == 0) take_gap = gap_len();
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            expected_answers.push_back(translate(pending_cmds.pop_front()));
            in_xfer = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            if (expected_answers.size() == 0) report("unexpected transfer", 0, 0);
            else begin
               e = expected_answers.pop_front();
               if (rsp_tdata[1:0] != e.st) report("status", rsp_tdata[1:0], e.st);
               if (rsp_tdata[22:2] != e.slot) report("slot", rsp_tdata[22:2], e.slot);
               if (rsp_tdata[30:23] != e.col) report("col", rsp_tdata[30:23], e.col);
               if (rsp_tdata[51:31] != e.row) report("row", rsp_tdata[51:31], e.row);
            end
         end
         if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      cmd_type c;
      int k;
      mdl_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: extremes and special cases
      c = make_cmd(OP_UPSERT, 16'h0000); c.w = 8'd255; c.h = 8'd255; c.cap = 16'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_UPSERT, 16'hFFFF); c.w = 8'd4; c.h = 8'd3; c.cap = 16'd5;
      pending_cmds.push_back(c);
      c = make_cmd(OP_UPSERT, 16'h0011); c.w = 8'd0; c.h = 8'd7; c.cap = 16'hFFFF;
      pending_cmds.push_back(c);
      c = make_cmd(OP_UPSERT, 16'h0022); c.w = 8'd6; c.h = 8'd0; c.cap = 16'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'h0000); c.px = 9'd255; c.py = 9'd255;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'h0000); c.px = 9'h100; c.py = 9'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'h0000); c.px = 9'd0; c.py = 9'h1FF;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'hFFFF); c.px = 9'd9; c.py = 9'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'hFFFF); c.px = 9'd1; c.py = 9'd1;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'h0011); c.px = 9'd0; c.py = 9'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_SLOT, 16'h1234); c.px = 9'd0; c.py = 9'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'hFFFF); c.slot = 21'd65027;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'hFFFF); c.slot = 21'd65030;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'hFFFF); c.slot = 21'd3;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'h0022); c.slot = 21'h1FFFFF;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'h0011); c.slot = 21'd65100;
      pending_cmds.push_back(c);
      c = make_cmd(OP_TO_POS, 16'h4321); c.slot = 21'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_UPSERT, 16'hFFFF); c.w = 8'd2; c.h = 8'd2; c.cap = 16'd0;
      pending_cmds.push_back(c);
      c = make_cmd(OP_NONE, 16'h0000);
      pending_cmds.push_back(c);
      for (int i = 0; i < 14; i++) begin
         c = make_cmd(OP_UPSERT, 16'(16'h0100 + i));
         pending_cmds.push_back(c);
      end
      c = make_cmd(OP_TO_POS, 16'h010D);
      pending_cmds.push_back(c);
      while (pending_cmds.size() > 0 || expected_answers.size() > 0) @(posedge clock);
      // random traffic in bursts against a small tag pool, with one sender pause
      for (int b = 0; b < 9; b++) begin
         if (b == 4) begin
            hold_sender = 1;
            while (expected_answers.size() > 0 || req_tvalid) @(posedge clock);
            hold_sender = 0;
         end
         for (int i = 0; i < 100; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20) c = make_cmd(OP_UPSERT, 16'(16'h0100 + $urandom_range(0, 19)));
            else if (k < 55) c = make_cmd(OP_TO_SLOT, 16'(16'h0100 + $urandom_range(0, 19)));
            else if (k < 92) c = make_cmd(OP_TO_POS, 16'(16'h0100 + $urandom_range(0, 19)));
            else c = make_cmd(op_type'($urandom_range(0, 3)), 16'($urandom));
            if (c.op == OP_UPSERT && $urandom_range(0, 2) == 0) begin
               c.w = 8'($urandom_range(1, 12));
               c.h = 8'($urandom_range(1, 12));
               c.cap = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 150));
            end
            if (c.op == OP_TO_SLOT && $urandom_range(0, 3) != 0) begin
               c.px = 9'($urandom_range(0, 15));
               c.py = 9'($urandom_range(0, 15));
            end
            if (c.op == OP_TO_POS && $urandom_range(0, 3) != 0)
               c.slot = 21'($urandom_range(0, 140000));
            pending_cmds.push_back(c);
         end
         while (pending_cmds.size() > 20) @(posedge clock);
      end
      stim_done = 1;
      while (pending_cmds.size() > 0 || expected_answers.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sgst_pkg.sv
rtl/sgst_ram.sv
rtl/sgst_div.sv
rtl/segmented_grid_slot_translator_core.sv
tb/testbench.sv
